[src/line_set_match_scorer_macros.svh]
// Assertion macros for the line set match scorer.
`ifndef LINE_SET_MATCH_SCORER_MACROS_SVH
`define LINE_SET_MATCH_SCORER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LSMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_set_match_scorer: check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LSMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_set_match_scorer: check failed");

`endif

[src/lsms_pkg.sv]
// Types, constants and the divider step shared by the line set match scorer.
package lsms_pkg;

  localparam int ANG_W     = 8;
  localparam int POS_W     = 12;
  localparam int LEN_W     = 13;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int SET_W     = 16;
  localparam int SCORE_W   = 17;
  localparam int TERM_W    = 30;              // one pair error, four terms
  localparam int SUM_W     = 34;              // sum of up to 16 pair errors
  localparam int DVD_W     = 34;              // divider dividend / quotient
  localparam int DVS_W     = 14;              // divider divisor
  localparam int REM_W     = DVS_W + 1;
  localparam int STEP_W    = 6;
  localparam int TERM_STEPS = LEN_W + FRAC_W; // dividend bits of one term

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL     = 2'd2;

  localparam logic [12:0] WIDTH_RESET    = 13'd2048;
  localparam logic [12:0] HEIGHT_RESET   = 13'd1536;
  localparam logic [13:0] DIAGONAL_RESET = 14'd2560;

  // |dangle| * 2^16 / 90 == (|dangle| * ceil(2^29 / 45)) >> 14, exact below 256
  localparam logic [31:0]        ANGLE_RECIP = 32'd11930465;
  localparam int                 ANGLE_SHIFT = 14;
  localparam logic [SCORE_W-1:0] SCORE_ONE   = 17'h10000;

  typedef struct packed {
    logic [ANG_W-1:0] ang;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] len;
  } line_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
  } div_lane_t;

  // One restoring division step: one quotient bit from the dividend MSB.
  function automatic div_lane_t div_step(div_lane_t l);
    div_lane_t r;
    logic [REM_W-1:0] sh;
    sh = {l.rem[REM_W-2:0], l.dvd[DVD_W-1]};
    r = l;
    r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
    if (sh >= {1'b0, l.dvs}) begin
      r.rem = sh - {1'b0, l.dvs};
      r.quo = {l.quo[DVD_W-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {l.quo[DVD_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[src/line_set_match_scorer.sv]
// Line set match scorer: loads line sets and scores candidate sets against the observed set.
`include "line_set_match_scorer_macros.svh"

// Observed lines (which_set = 1) and candidate lines (which_set = 0) load
// one per cycle, while in_stall is low, into two 16-entry line memories. The
// transfer that carries a candidate's last line starts scoring, and the input
// stalls until the result has been placed in the output register. Scoring has
// three phases. First every pair (small-set line i, large-set line j) gets its
// error written into a pair error memory: line memory read, operand load, 29
// steps of three one-bit-per-cycle restoring divider lanes for the position
// and length terms, then write; the angle term comes from a reciprocal
// multiply at operand load. Then every k-subset of the larger set is walked;
// each pairing sums k entries through the error memory's single read port,
// and the smallest sum is kept. Last, one divider lane turns the smallest sum
// into 65536 - sum/(4k), or 0 where sum/(4k) reaches 65536. If either set is
// empty, the phases are skipped and the score is 0. The output register is
// free to hold one result while the next lines load.
module line_set_match_scorer
  import lsms_pkg::*;
#(
  parameter int MAX_LINES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input line channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 which_set,
  input  logic signed [ANG_W-1:0] line_angle,
  input  logic [POS_W-1:0]     line_xpos,
  input  logic [POS_W-1:0]     line_ypos,
  input  logic [LEN_W-1:0]     line_length,
  input  logic                 last_of_set,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SET_W-1:0]     set_number,
  output logic [SCORE_W-1:0]   set_score,
  output logic [SET_W-1:0]     best_set,
  output logic [SCORE_W-1:0]   best_score
);

  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int CW1       = CNT_W + 1;
  localparam int ERR_AW    = 2 * IDX_W;
  localparam int ERR_DEPTH = 1 << ERR_AW;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SETUP     = 4'd1;
  localparam logic [3:0] S_PRE_RD    = 4'd2;
  localparam logic [3:0] S_PRE_LD    = 4'd3;
  localparam logic [3:0] S_PRE_DIV   = 4'd4;
  localparam logic [3:0] S_PRE_WR    = 4'd5;
  localparam logic [3:0] S_ENUM_INIT = 4'd6;
  localparam logic [3:0] S_ENUM      = 4'd7;
  localparam logic [3:0] S_FIN_LD    = 4'd8;
  localparam logic [3:0] S_FIN_DIV   = 4'd9;
  localparam logic [3:0] S_FIN_OUT   = 4'd10;

  // configuration
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [13:0] diagonal_length;

  // control
  logic [3:0]       state;
  logic [CNT_W-1:0] obs_count;
  logic [CNT_W-1:0] mdl_count;
  logic             obs_closed;
  logic [SET_W-1:0] set_counter;
  logic [SCORE_W-1:0] top_score;
  logic [SET_W-1:0]   top_set;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] n;
  logic             model_small;
  logic [IDX_W-1:0] pi;
  logic [IDX_W-1:0] pj;
  logic [STEP_W-1:0] step_cnt;
  logic [CNT_W-1:0] ei;
  logic             rd_pend;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] best_sum;
  logic [SCORE_W-1:0] score_reg;
  logic [TERM_W-1:0] ang_term;

  // memories
  line_t            obs_mem [MAX_LINES];
  line_t            mdl_mem [MAX_LINES];
  logic [TERM_W-1:0] err_mem [ERR_DEPTH];
  line_t            obs_rd;
  line_t            mdl_rd;
  logic [TERM_W-1:0] err_rdata;

  div_lane_t        lane [4];
  logic [IDX_W-1:0] c [MAX_LINES];
  logic [IDX_W-1:0] c_next [MAX_LINES];

  // combinational
  logic             in_xfer;
  logic             out_free;
  line_t            in_line;
  logic             obs_we;
  logic             mdl_we;
  logic [IDX_W-1:0] obs_wa;
  logic [IDX_W-1:0] obs_ra;
  logic [IDX_W-1:0] mdl_ra;
  logic [ERR_AW-1:0] err_raddr;
  logic [TERM_W-1:0] pair_err;
  logic [8:0]       ang_diff;
  logic [7:0]       ang_abs;
  logic [31:0]      ang_prod;
  logic [12:0]      x_diff;
  logic [11:0]      x_abs;
  logic [12:0]      y_diff;
  logic [11:0]      y_abs;
  logic [13:0]      len_diff;
  logic [12:0]      len_abs;
  logic [DVS_W-1:0] wdiv;
  logic [DVS_W-1:0] hdiv;
  logic [DVS_W-1:0] ddiv;
  logic [MAX_LINES-1:0] can_inc;
  logic             inc_found;
  logic [IDX_W-1:0] jsel;
  logic [CNT_W-1:0] nm_k;
  logic [CNT_W-1:0] nm_n;
  logic             nm_small;
  logic             new_top;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign in_line = '{ang: line_angle, x: line_xpos, y: line_ypos, len: line_length};

  // an observed line after a closed set restarts the set at entry 0
  assign obs_wa = obs_closed ? '0 : obs_count[IDX_W-1:0];
  assign obs_we = in_xfer && which_set &&
                  (obs_closed || (obs_count < CNT_W'(MAX_LINES)));
  assign mdl_we = in_xfer && !which_set && (mdl_count < CNT_W'(MAX_LINES));

  assign obs_ra = model_small ? pj : pi;
  assign mdl_ra = model_small ? pi : pj;
  assign err_raddr = {ei[IDX_W-1:0], c[ei[IDX_W-1:0]]};

  // zero divisor acts as one
  assign wdiv = (image_width == '0)     ? DVS_W'(1) : {1'b0, image_width};
  assign hdiv = (image_height == '0)    ? DVS_W'(1) : {1'b0, image_height};
  assign ddiv = (diagonal_length == '0) ? DVS_W'(1) : diagonal_length;

  // absolute differences of the two lines just read
  always_comb begin
    ang_diff = {obs_rd.ang[ANG_W-1], obs_rd.ang} - {mdl_rd.ang[ANG_W-1], mdl_rd.ang};
    ang_abs  = ang_diff[8] ? 8'(-ang_diff) : ang_diff[7:0];
    x_diff   = {1'b0, obs_rd.x} - {1'b0, mdl_rd.x};
    x_abs    = x_diff[12] ? 12'(-x_diff) : x_diff[11:0];
    y_diff   = {1'b0, obs_rd.y} - {1'b0, mdl_rd.y};
    y_abs    = y_diff[12] ? 12'(-y_diff) : y_diff[11:0];
    len_diff = {1'b0, obs_rd.len} - {1'b0, mdl_rd.len};
    len_abs  = len_diff[13] ? 13'(-len_diff) : len_diff[12:0];
  end

  // angle term by reciprocal multiply, below 2^18
  assign ang_prod = 32'(ang_abs) * ANGLE_RECIP;

  // four terms each below 2^29, sum stays below 2^30
  assign pair_err = ang_term + TERM_W'(lane[1].quo) +
                    TERM_W'(lane[2].quo) + TERM_W'(lane[3].quo);

  // set sizes as they stand once the last candidate line is in
  assign nm_small = mdl_count < obs_count;
  assign nm_k     = nm_small ? mdl_count : obs_count;
  assign nm_n     = nm_small ? obs_count : mdl_count;

  // next k-subset: highest position that can still move up
  always_comb begin
    inc_found = 1'b0;
    jsel      = '0;
    for (int jj = 0; jj < MAX_LINES; jj++) begin
      can_inc[jj] = (CNT_W'(jj) < k) &&
                    (CW1'(c[jj]) + CW1'(k) < CW1'(n) + CW1'(jj));
      if (can_inc[jj]) begin
        inc_found = 1'b1;
        jsel      = IDX_W'(jj);
      end
    end
    for (int ii = 0; ii < MAX_LINES; ii++) begin
      if (IDX_W'(ii) >= jsel) begin
        c_next[ii] = c[jsel] + IDX_W'(ii) - jsel + IDX_W'(1);
      end else begin
        c_next[ii] = c[ii];
      end
    end
  end

  assign new_top = score_reg > top_score;

  // line memories
  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_wa] <= in_line;
    end
    if (mdl_we) begin
      mdl_mem[mdl_count[IDX_W-1:0]] <= in_line;
    end
    obs_rd <= obs_mem[obs_ra];
    mdl_rd <= mdl_mem[mdl_ra];
  end

  // pair error memory
  always_ff @(posedge clk) begin
    if (state == S_PRE_WR) begin
      err_mem[{pi, pj}] <= pair_err;
    end
    err_rdata <= err_mem[err_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
      diagonal_length <= DIAGONAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width     <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height    <= cfg_data[12:0];
        REG_DIAGONAL:     diagonal_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      obs_count   <= '0;
      mdl_count   <= '0;
      obs_closed  <= 1'b0;
      set_counter <= '0;
      top_score   <= '0;
      top_set     <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (which_set) begin
              if (obs_closed) begin
                obs_count <= CNT_W'(1);
              end else if (obs_count < CNT_W'(MAX_LINES)) begin
                obs_count <= obs_count + CNT_W'(1);
              end
              obs_closed <= last_of_set;
            end else begin
              if (mdl_count < CNT_W'(MAX_LINES)) begin
                mdl_count <= mdl_count + CNT_W'(1);
              end
              if (last_of_set) begin
                state <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          model_small <= nm_small;
          k  <= nm_k;
          n  <= nm_n;
          pi <= '0;
          pj <= '0;
          if (nm_k == '0) begin
            score_reg <= '0;
            state     <= S_FIN_OUT;
          end else begin
            state <= S_PRE_RD;
          end
        end
        S_PRE_RD: begin
          state <= S_PRE_LD;
        end
        S_PRE_LD: begin
          ang_term <= TERM_W'(ang_prod >> ANGLE_SHIFT);
          lane[1] <= '{dvd: {1'b0, x_abs, 21'd0}, rem: '0, quo: '0, dvs: wdiv};
          lane[2] <= '{dvd: {1'b0, y_abs, 21'd0}, rem: '0, quo: '0, dvs: hdiv};
          lane[3] <= '{dvd: {len_abs, 21'd0}, rem: '0, quo: '0, dvs: ddiv};
          step_cnt <= STEP_W'(TERM_STEPS);
          state    <= S_PRE_DIV;
        end
        S_PRE_DIV: begin
          for (int l = 1; l < 4; l++) begin
            lane[l] <= div_step(lane[l]);
          end
          step_cnt <= step_cnt - STEP_W'(1);
          if (step_cnt == STEP_W'(1)) begin
            state <= S_PRE_WR;
          end
        end
        S_PRE_WR: begin
          if (CNT_W'(pj) == n - CNT_W'(1)) begin
            pj <= '0;
            if (CNT_W'(pi) == k - CNT_W'(1)) begin
              state <= S_ENUM_INIT;
            end else begin
              pi    <= pi + IDX_W'(1);
              state <= S_PRE_RD;
            end
          end else begin
            pj    <= pj + IDX_W'(1);
            state <= S_PRE_RD;
          end
        end
        S_ENUM_INIT: begin
          for (int ii = 0; ii < MAX_LINES; ii++) begin
            c[ii] <= IDX_W'(ii);
          end
          best_sum <= '1;
          acc      <= '0;
          ei       <= '0;
          rd_pend  <= 1'b0;
          state    <= S_ENUM;
        end
        S_ENUM: begin
          // issue one error read per cycle, add it in the next cycle
          if (ei < k) begin
            ei      <= ei + CNT_W'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            acc <= acc + SUM_W'(err_rdata);
          end
          if ((ei == k) && !rd_pend) begin
            if (acc < best_sum) begin
              best_sum <= acc;
            end
            acc <= '0;
            ei  <= '0;
            if (inc_found) begin
              c <= c_next;
            end else begin
              state <= S_FIN_LD;
            end
          end
        end
        S_FIN_LD: begin
          lane[0]  <= '{dvd: best_sum, rem: '0, quo: '0,
                        dvs: DVS_W'({k, 2'b00})};
          step_cnt <= STEP_W'(DVD_W);
          state    <= S_FIN_DIV;
        end
        S_FIN_DIV: begin
          lane[0]  <= div_step(lane[0]);
          step_cnt <= step_cnt - STEP_W'(1);
          if (step_cnt == '0) begin
            if (lane[0].quo >= DVD_W'(SCORE_ONE)) begin
              score_reg <= '0;
            end else begin
              score_reg <= SCORE_ONE - SCORE_W'(lane[0].quo);
            end
            state <= S_FIN_OUT;
          end
        end
        S_FIN_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            set_number <= set_counter;
            set_score  <= score_reg;
            best_set   <= new_top ? set_counter : top_set;
            best_score <= new_top ? score_reg : top_score;
            if (new_top) begin
              top_score <= score_reg;
              top_set   <= set_counter;
            end
            set_counter <= set_counter + SET_W'(1);
            mdl_count   <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LSMS_ASSERT_NOW(a_best_covers_set, out_valid, best_score >= set_score)
  `LSMS_ASSERT_NOW(a_counts_bounded, in_valid || !in_valid, (obs_count <= CNT_W'(MAX_LINES)) && (mdl_count <= CNT_W'(MAX_LINES)))
  `LSMS_ASSERT_NEXT(a_result_issued, (state == S_FIN_OUT) && out_free, out_valid && (state == S_IDLE) && (mdl_count == '0))

endmodule
